// ===== rtl/mtf_pkg.sv =====
// Package for the move-to-front list: list capacity, derived widths, request
// and status codes, and the control bundle from the top level to the cells.
// No dependencies.
package mtf_pkg;

    localparam int CAPACITY = 16;
    localparam int SYM_W    = 8;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic
    {
        REQ_APPEND = 1'b0,
        REQ_MOVE   = 1'b1
    } req_t;

    typedef enum logic [1:0]
    {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed
    {
        logic move_fire;    // accepted move request
        logic found;        // some valid cell matched the symbol
        logic append_fire;  // accepted append request on a list that is not full
    } cell_ctrl_t;

endpackage

// ===== rtl/mtf_cell.sv =====
// One list cell: holds a single symbol, compares it against the request and
// either shifts in its neighbour's symbol or stores an appended one.
// Depends on mtf_pkg.
module mtf_cell
(
    input  logic                       clk,
    input  mtf_pkg::cell_ctrl_t        ctrl,
    input  logic [mtf_pkg::SYM_W-1:0]  symbol,
    input  logic [mtf_pkg::SYM_W-1:0]  prev_entry,
    input  logic                       valid,
    input  logic                       append_sel,
    input  logic                       seen_in,
    output logic                       seen_out,
    output logic [mtf_pkg::SYM_W-1:0]  entry
);
    import mtf_pkg::*;

    logic [SYM_W-1:0] entry_reg;
    logic [SYM_W-1:0] entry_next;
    logic             hit;
    logic             shift;
    logic             write_app;

    // A cell shifts when the first match lies at or behind it.
    assign hit       = valid && (entry_reg == symbol);
    assign seen_out  = seen_in || hit;
    assign shift     = ctrl.move_fire && ctrl.found && !seen_in;
    assign write_app = ctrl.append_fire && append_sel;

    always_comb
    begin
        priority if (shift)
        begin
            entry_next = prev_entry;
        end
        else if (write_app)
        begin
            entry_next = symbol;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/move_to_front_list_core.sv =====
// Top level of the move-to-front list: stream handshake, fill count, result
// register and the row of list cells.
// Depends on mtf_pkg and mtf_cell.
//
// Usage. Requests arrive as words on the s_ channel: s_tuser carries the kind
// of request (append at the tail, or move the first matching symbol to the
// head) and s_tdata carries the symbol. Each request gives exactly one status
// word on the m_ channel: done, not found (which covers an empty list) or full.
// All cells compare their symbol with the request in parallel, a ripple of
// "already matched" flags runs along the row to pick the first match, and in
// the same cycle every cell from the head up to that match takes its
// neighbour's symbol while the head takes the requested one. An append writes
// the cell indexed by the fill count. A request therefore completes in the
// cycle it is accepted; its registered status shows on the m_ channel in the
// cycle after. While the receiver keeps up, a new request can be accepted
// every cycle. The status register parts the two sides: when the receiver
// stalls, one result is held and a further request is accepted only in a
// cycle where that result leaves. Reset empties the list (fill count to zero)
// and drops any pending result; the cell contents are not cleared.
module move_to_front_list_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic [0:0] s_tuser,   // [0] req_type
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [1:0] status, [7:2] zero
);
    import mtf_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    status_t          status_reg;
    status_t          status_next;

    logic             s_fire;
    req_t             req;
    logic [SYM_W-1:0] symbol;
    logic             full;
    logic             found;
    cell_ctrl_t       ctrl;

    logic [CAPACITY:0]  seen;
    logic [SYM_W-1:0]   entry [CAPACITY];
    logic [CAPACITY-1:0] valid;
    logic [CAPACITY-1:0] append_sel;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign req      = req_t'(s_tuser[0]);
    assign symbol   = s_tdata[SYM_W-1:0];
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign found    = seen[CAPACITY];

    assign ctrl.move_fire   = s_fire && (req == REQ_MOVE);
    assign ctrl.found       = found;
    assign ctrl.append_fire = s_fire && (req == REQ_APPEND) && !full;

    assign seen[0] = 1'b0;

    // The row of cells; the head takes the requested symbol when it shifts.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign valid[i]      = (count_reg > CNT_W'(i));
        assign append_sel[i] = (count_reg == CNT_W'(i));

        if (i == 0)
        begin : g_head
            mtf_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl),
                .symbol     (symbol),
                .prev_entry (symbol),
                .valid      (valid[i]),
                .append_sel (append_sel[i]),
                .seen_in    (seen[i]),
                .seen_out   (seen[i+1]),
                .entry      (entry[i])
            );
        end
        else
        begin : g_body
            mtf_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl),
                .symbol     (symbol),
                .prev_entry (entry[i-1]),
                .valid      (valid[i]),
                .append_sel (append_sel[i]),
                .seen_in    (seen[i]),
                .seen_out   (seen[i+1]),
                .entry      (entry[i])
            );
        end
    end

    // The fill count grows only on an append that finds room.
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.append_fire)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        status_next = status_reg;
        if (s_fire)
        begin
            unique case (req)
                REQ_APPEND: status_next = full  ? ST_FULL : ST_DONE;
                REQ_MOVE:   status_next = found ? ST_DONE : ST_NOT_FOUND;
                default:    status_next = ST_NOT_FOUND;
            endcase
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (s_fire)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, status_reg};

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // The count moves only on an append that found room, and then by one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.append_fire |=> $stable(count_reg))
        else $error("fill count changed without an append");

    // An append to a full list reports full.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (req == REQ_APPEND) && full) |=> (m_tdata[1:0] == ST_FULL))
        else $error("append to a full list did not report full");

    // A move on an empty list can never find its symbol.
    a_empty_move: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (req == REQ_MOVE) && (count_reg == '0))
            |=> (m_tdata[1:0] == ST_NOT_FOUND))
        else $error("move on an empty list did not report not found");

    // Every accepted request leaves a result waiting on the output.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> m_tvalid)
        else $error("accepted request gave no result");

endmodule

// ===== verif/move_to_front_list_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for move_to_front_list_core: drives append and move
// requests over the stream ports and checks every status word against a list
// model kept here. Depends on mtf_pkg and the RTL of the core.
module move_to_front_list_core_tb;

    import mtf_pkg::*;

    typedef enum logic
    {
        RX_STEADY  = 1'b0,
        RX_PATTERN = 1'b1
    } rx_style_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] symbol
    logic [0:0] s_tuser;   // [0] req_type
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [1:0] status, [7:2] zero

    // List model: head at index 0, fill entries valid.
    logic [SYM_W-1:0] mtf_list [CAPACITY];
    int               fill;

    // Status words owed by the core, oldest first.
    status_t          status_due [$];

    int               fail_count;
    int               append_count;
    int               move_count;
    int               done_count;
    int               miss_count;
    int               full_count;
    int               word_count;

    // Sender and receiver behaviour, changed by the test tasks.
    logic             tx_gaps;
    int               burst_left;
    rx_style_t        rx_style;
    int               hold_req;

    move_to_front_list_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Applies one request to the list model and returns the status it earns.
    function automatic status_t mtf_apply(input req_t req, input logic [SYM_W-1:0] sym);
        int pos;
        if (req == REQ_APPEND)
        begin
            if (fill >= CAPACITY)
                return ST_FULL;
            mtf_list[fill] = sym;
            fill++;
            return ST_DONE;
        end
        // The first match counted from the head is the one that moves.
        pos = -1;
        for (int i = fill - 1; i >= 0; i--)
            if (mtf_list[i] == sym)
                pos = i;
        if (pos < 0)
            return ST_NOT_FOUND;
        for (int i = pos; i > 0; i--)
            mtf_list[i] = mtf_list[i - 1];
        mtf_list[0] = sym;
        return ST_DONE;
    endfunction

    // Offers one request and waits for the handshake. In burst mode the
    // sender drops tvalid for a random gap whenever a burst runs out.
    task automatic send_request(input req_t req, input logic [SYM_W-1:0] sym);
        int      gap;
        status_t st;
        if (tx_gaps)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 5);
                burst_left = $urandom_range(1, 12);
                repeat (gap)
                begin
                    @(negedge clk);
                    s_tvalid <= 1'b0;
                end
            end
            burst_left--;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tuser  <= req;
        do
            @(posedge clk);
        while (!s_tready);
        st = mtf_apply(req, sym);
        status_due.push_back(st);
        if (req == REQ_APPEND)
            append_count++;
        else
            move_count++;
        case (st)
            ST_DONE:      done_count++;
            ST_NOT_FOUND: miss_count++;
            default:      full_count++;
        endcase
    endtask

    // Mostly symbols that are in the list, at any depth, so that moves hit;
    // the rest are arbitrary bytes, which usually miss.
    function automatic logic [SYM_W-1:0] pick_symbol();
        int roll;
        roll = $urandom_range(0, 99);
        if (fill > 0 && roll < 10)
            return mtf_list[0];
        if (fill > 0 && roll < 70)
            return mtf_list[$urandom_range(0, fill - 1)];
        return SYM_W'($urandom_range(0, 255));
    endfunction

    task automatic send_random(input int append_pct);
        if ($urandom_range(0, 99) < append_pct)
            send_request(REQ_APPEND, pick_symbol());
        else
            send_request(REQ_MOVE, pick_symbol());
    endtask

    // A move on the empty list must report not found.
    task automatic test_empty_list();
        send_request(REQ_MOVE, 8'h00);
        send_request(REQ_MOVE, 8'hFF);
    endtask

    // Extreme symbols, a duplicate, a move of the head, a move of the first of
    // two equal entries, a move from the tail and a move of a missing symbol.
    task automatic test_special_cases();
        send_request(REQ_APPEND, 8'h00);
        send_request(REQ_APPEND, 8'hFF);
        send_request(REQ_APPEND, 8'hA5);
        send_request(REQ_APPEND, 8'hA5);
        send_request(REQ_APPEND, 8'h5A);
        send_request(REQ_MOVE,   8'h00);
        send_request(REQ_MOVE,   8'hA5);
        send_request(REQ_MOVE,   8'h5A);
        send_request(REQ_MOVE,   8'h33);
    endtask

    // Grows the list to capacity with moves mixed in at every fill level,
    // then appends twice more to a full list.
    task automatic test_growing_list();
        while (fill < CAPACITY)
            send_random(40);
        send_request(REQ_APPEND, 8'h00);
        send_request(REQ_APPEND, 8'hFF);
    endtask

    task automatic test_random_traffic(input int n_items, input logic gaps,
                                       input rx_style_t style);
        tx_gaps  = gaps;
        rx_style = style;
        repeat (n_items)
            send_random(15);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering back to back, so the core fills up and stalls its input.
    task automatic test_backpressure();
        tx_gaps  = 1'b0;
        rx_style = RX_STEADY;
        hold_req = 300;
        repeat (40)
            send_random(15);
    endtask

    task automatic finish_run();
        int waited;
        @(negedge clk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (status_due.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8)
            @(posedge clk);
        if (status_due.size() != 0)
        begin
            $display("%0t: %0d status words never arrived", $time, status_due.size());
            fail_count++;
        end
        $display("Covered %0d requests: %0d appends and %0d moves, %0d status words checked.",
                 append_count + move_count, append_count, move_count, word_count);
        $display("Outcomes seen: %0d done, %0d not found or empty, %0d full.",
                 done_count, miss_count, full_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    endtask

    // Stimulus sequence.
    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        fill         = 0;
        fail_count   = 0;
        append_count = 0;
        move_count   = 0;
        done_count   = 0;
        miss_count   = 0;
        full_count   = 0;
        word_count   = 0;
        tx_gaps      = 1'b0;
        burst_left   = 0;
        rx_style     = RX_STEADY;
        hold_req     = 0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_special_cases();
        tx_gaps  = 1'b1;
        rx_style = RX_PATTERN;
        test_growing_list();
        test_random_traffic(900, 1'b1, RX_PATTERN);
        test_backpressure();
        test_random_traffic(440, 1'b0, RX_STEADY);
        test_random_traffic(440, 1'b0, RX_PATTERN);
        finish_run();
    end

    // Receiver: steady, or a rotating random stall pattern that is redrawn
    // each time it wraps round and is sometimes all ready. A hold-off request
    // overrides both for the given number of cycles.
    initial
    begin : receiver
        logic [15:0] rx_pattern;
        int          rx_phase;
        int          hold_left;
        rx_pattern = 16'hFFFF;
        rx_phase   = 0;
        hold_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (rx_style == RX_STEADY)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= rx_pattern[rx_phase];
                rx_phase++;
                if (rx_phase == 16)
                begin
                    rx_phase = 0;
                    if ($urandom_range(0, 3) == 0)
                        rx_pattern = 16'hFFFF;
                    else
                        rx_pattern = 16'($urandom) | (16'd1 << $urandom_range(0, 15));
                end
            end
        end
    end

    // Status checker: every word taken from the core is matched, field by
    // field, with the oldest status still owed.
    always @(posedge clk)
    begin
        status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            word_count++;
            if (status_due.size() == 0)
            begin
                $display("%0t: unexpected status word, expected none, actual 0x%02h",
                         $time, m_tdata);
                fail_count++;
            end
            else
            begin
                want = status_due.pop_front();
                if (m_tdata[1:0] !== want)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want, m_tdata[1:0]);
                    fail_count++;
                end
                if (m_tdata[7:2] !== 6'd0)
                begin
                    $display("%0t: padding mismatch, expected 0x00, actual 0x%02h",
                             $time, m_tdata[7:2]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #4000000;
        $display("%0t: run timed out with %0d status words outstanding",
                 $time, status_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mtf_pkg.sv
rtl/mtf_cell.sv
rtl/move_to_front_list_core.sv
verif/move_to_front_list_core_tb.sv
